@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the slow PWM block.
// No dependencies; included by multi_channel_slow_pwm.sv, which carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked at the next clock, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ sv/mcsp_pkg.sv @@
// Package for the multi-channel slow PWM: widths, constants and command codes.
// No dependencies; used by the channel interfaces and the top level.
package mcsp_pkg;

   localparam int CHANNELS     = 4;
   localparam int NUM_SETTINGS = 4;
   localparam int CHAN_W       = $clog2(NUM_SETTINGS);
   localparam int SETTING_W    = 16;
   localparam int ELAPSED_W    = 10;
   localparam int ACC_W        = 16;
   localparam int COUNT_W      = 8;

   localparam logic [ACC_W-1:0] MS_PER_SECOND = ACC_W'(1000);

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_ENABLE = 1'b1
   } command_type;

   typedef logic [NUM_SETTINGS-1:0] chan_mask_type;

   function automatic logic [COUNT_W-1:0] period_of(input logic [SETTING_W-1:0] setting);
      return setting[SETTING_W-1 -: COUNT_W];
   endfunction

   function automatic logic [COUNT_W-1:0] on_time_of(input logic [SETTING_W-1:0] setting);
      return setting[COUNT_W-1:0];
   endfunction

endpackage

@@ sv/mcsp_req_if.sv @@
// Request channel of the slow PWM: valid/ready handshake with a command payload.
// Depends on mcsp_pkg.
interface mcsp_req_if import mcsp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   command_type          command;
   logic [CHAN_W-1:0]    channel;
   logic                 enable;
   logic [ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, command, channel, enable, elapsed_ms, input ready);
   modport sink   (input valid, command, channel, enable, elapsed_ms, output ready);
endinterface

@@ sv/mcsp_rsp_if.sv @@
// Response channel of the slow PWM: valid/ready handshake with pin and enable state.
// Depends on mcsp_pkg.
interface mcsp_rsp_if import mcsp_pkg::*; ();
   logic          valid;
   logic          ready;
   chan_mask_type pin_levels;
   chan_mask_type enabled_mask;

   modport source (output valid, pin_levels, enabled_mask, input ready);
   modport sink   (input valid, pin_levels, enabled_mask, output ready);
endinterface

@@ sv/multi_channel_slow_pwm.sv @@
// Four-channel slow PWM for relay outputs. A transaction's response is registered and is
// valid in the cycle after it is accepted. Throughput: one transaction per cycle; the
// request side is held off only while a response waits untaken.
// All channel counters advance together, enabled or not, on a tick that completes a second.
// Reset (synchronous, active high) clears settings, accumulator, counters, enables,
// pins and the response valid flag.
`include "assert_macros.svh"

module multi_channel_slow_pwm import mcsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mcsp_req_if.sink             req_bus,
   mcsp_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CHAN_W-1:0]    csr_index,
   input  logic [SETTING_W-1:0] csr_wdata
);

   logic [SETTING_W-1:0] setting_ff [NUM_SETTINGS];
   logic [COUNT_W-1:0]   counter_ff [NUM_SETTINGS];
   logic [COUNT_W-1:0]   counter_in [NUM_SETTINGS];
   logic [COUNT_W-1:0]   counter_step [NUM_SETTINGS];
   logic [ACC_W-1:0]     acc_ff, acc_in, acc_sum;
   chan_mask_type        enable_ff, enable_in;
   chan_mask_type        pin_ff, pin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 second_due;

   // the response payload is the state itself: it only moves on an accepted transaction
   assign req_bus.ready        = !rsp_valid_ff || rsp_bus.ready;
   assign accept               = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pin_levels   = pin_ff;
   assign rsp_bus.enabled_mask = enable_ff;

   always_comb begin
      acc_sum    = acc_ff + ACC_W'(req_bus.elapsed_ms);
      second_due = acc_sum >= MS_PER_SECOND;
      for (int ch = 0; ch < NUM_SETTINGS; ch++) begin
         counter_step[ch] = counter_ff[ch] + COUNT_W'(1);
         if (counter_step[ch] >= period_of(setting_ff[ch])) begin
            counter_step[ch] = '0;
         end
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      counter_in   = counter_ff;
      enable_in    = enable_ff;
      pin_in       = pin_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_bus.command)
            CMD_TICK: begin
               acc_in = second_due ? acc_sum - MS_PER_SECOND : acc_sum;
               if (second_due) begin
                  for (int ch = 0; ch < NUM_SETTINGS; ch++) begin
                     if (ch < CHANNELS) begin
                        counter_in[ch] = counter_step[ch];
                        pin_in[ch]     = (counter_step[ch] < on_time_of(setting_ff[ch]))
                                         && enable_ff[ch];
                     end
                  end
               end
            end
            CMD_ENABLE: begin
               if (int'(req_bus.channel) < CHANNELS) begin
                  if (req_bus.enable) begin
                     // switching on restarts the period; already-on channels are left alone
                     if (!enable_ff[req_bus.channel]) begin
                        enable_in[req_bus.channel]  = 1'b1;
                        counter_in[req_bus.channel] = '0;
                        pin_in[req_bus.channel]     =
                           on_time_of(setting_ff[req_bus.channel]) != '0;
                     end
                  end else begin
                     enable_in[req_bus.channel] = 1'b0;
                     pin_in[req_bus.channel]    = 1'b0;
                  end
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         enable_ff    <= '0;
         pin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int ch = 0; ch < NUM_SETTINGS; ch++) begin
            setting_ff[ch] <= '0;
            counter_ff[ch] <= '0;
         end
      end else begin
         acc_ff       <= acc_in;
         enable_ff    <= enable_in;
         pin_ff       <= pin_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         if (csr_we) begin
            setting_ff[csr_index] <= csr_wdata;
         end
      end
   end

   `ASSERT_CLK(a_pin_needs_enable, clock, reset, (pin_ff & ~enable_ff) == '0,
      "pin driven high on a disabled channel")
   `ASSERT_NEXT(a_rsp_follows_accept, clock, reset, accept, rsp_valid_ff,
      "no response after an accepted transaction")
   `ASSERT_NEXT(a_disable_clears, clock, reset,
      accept && req_bus.command == CMD_ENABLE && !req_bus.enable,
      !enable_ff[$past(req_bus.channel)] && !pin_ff[$past(req_bus.channel)],
      "disable transaction left channel enabled or pin high")
   `ASSERT_NEXT(a_state_holds_on_stall, clock, reset, !accept,
      $stable(pin_ff) && $stable(enable_ff) && $stable(acc_ff),
      "state moved without an accepted transaction")

endmodule

@@ tb/sv/tb_multi_channel_slow_pwm.sv @@
// Self-checking testbench for the four-channel slow PWM: a scoreboard class predicts
// pin levels and enable mask per transaction; plain tasks drive requests and settings.
// Depends on mcsp_pkg, mcsp_req_if, mcsp_rsp_if and multi_channel_slow_pwm.
import mcsp_pkg::*;

typedef struct packed {
   chan_mask_type pins;
   chan_mask_type mask;
} pwm_status_type;

class pwm_scoreboard;
   logic [SETTING_W-1:0] setting [NUM_SETTINGS];
   logic [ACC_W-1:0]     ms_total;
   logic [COUNT_W-1:0]   sec_count [NUM_SETTINGS];
   chan_mask_type        en_bits;
   chan_mask_type        pin_bits;
   pwm_status_type       status_q [$];
   int                   field_errors, strays, reported;
   int                   checked, ticks, seconds, enable_cmds, setting_writes;

   function void clear();
      for (int i = 0; i < NUM_SETTINGS; i++) begin
         setting[i]   = '0;
         sec_count[i] = '0;
      end
      ms_total = '0;
      en_bits  = '0;
      pin_bits = '0;
   endfunction

   function void write_setting(int idx, logic [SETTING_W-1:0] value);
      setting[idx] = value;
      setting_writes++;
   endfunction

   function void note_request(command_type cmd, logic [CHAN_W-1:0] ch, logic en,
                              logic [ELAPSED_W-1:0] ms);
      logic [COUNT_W-1:0] cnt;
      if (cmd == CMD_TICK) begin
         ticks++;
         ms_total = ms_total + ACC_W'(ms);
         if (ms_total >= MS_PER_SECOND) begin
            ms_total = ms_total - MS_PER_SECOND;
            seconds++;
            // every channel advances, enabled or not
            for (int i = 0; i < CHANNELS; i++) begin
               cnt = sec_count[i] + 1'b1;
               if (cnt >= setting[i][SETTING_W-1 -: COUNT_W])
                  cnt = '0;
               sec_count[i] = cnt;
               pin_bits[i]  = (cnt < setting[i][COUNT_W-1:0]) && en_bits[i];
            end
         end
      end else begin
         enable_cmds++;
         if (en) begin
            if (!en_bits[ch]) begin
               en_bits[ch]   = 1'b1;
               sec_count[ch] = '0;
               pin_bits[ch]  = (setting[ch][COUNT_W-1:0] != '0);
            end
         end else begin
            en_bits[ch]  = 1'b0;
            pin_bits[ch] = 1'b0;
         end
      end
      status_q.push_back(pwm_status_type'{pins: pin_bits, mask: en_bits});
   endfunction

   function void check_response(chan_mask_type pins, chan_mask_type mask);
      pwm_status_type exp_status;
      checked++;
      if (status_q.size() == 0) begin
         strays++;
         if (reported < 10)
            $display("unexpected transaction on response: pins %b mask %b", pins, mask);
         reported++;
         return;
      end
      exp_status = status_q.pop_front();
      if (exp_status.pins !== pins || exp_status.mask !== mask) begin
         field_errors++;
         if (reported < 10)
            $display("status error: expected pins %b mask %b, got pins %b mask %b",
                     exp_status.pins, exp_status.mask, pins, mask);
         reported++;
      end
   endfunction

   function int pending();
      return status_q.size();
   endfunction

   function int failures();
      return field_errors + strays + status_q.size();
   endfunction
endclass

module tb_multi_channel_slow_pwm;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CHAN_W-1:0]    csr_index;
   logic [SETTING_W-1:0] csr_wdata;
   bit                   calm;
   int                   phases;
   pwm_scoreboard        sb;

   mcsp_req_if req_bus ();
   mcsp_rsp_if rsp_bus ();

   multi_channel_slow_pwm DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: ready drops with a probability of 19 in 100 unless in the calm stretch
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // check the response before noting the new request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.pin_levels, rsp_bus.enabled_mask);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.command, req_bus.channel, req_bus.enable,
                            req_bus.elapsed_ms);
      end
   end

   task automatic send_request(input command_type cmd, input logic [CHAN_W-1:0] ch,
                               input logic en, input logic [ELAPSED_W-1:0] ms);
      if (!calm && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.channel    <= ch;
      req_bus.enable     <= en;
      req_bus.elapsed_ms <= ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // drop valid and let the last accepted transaction reach the scoreboard before it drains
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic load_settings(input logic [NUM_SETTINGS-1:0][SETTING_W-1:0] vals);
      for (int i = 0; i < NUM_SETTINGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CHAN_W'(i);
         csr_wdata <= vals[i];
         sb.write_setting(i, vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      phases++;
   endtask

   // mostly short periods so pins toggle often, with the odd extreme
   function automatic logic [SETTING_W-1:0] pick_setting();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hFF00;
         3:       return {8'h00, 8'($urandom_range(255))};
         4:       return 16'($urandom_range(65535));
         default: return {8'($urandom_range(6)), 8'($urandom_range(7))};
      endcase
   endfunction

   task automatic random_request();
      logic [ELAPSED_W-1:0] ms;
      case ($urandom_range(3))
         0:       ms = ELAPSED_W'($urandom_range(1023));
         1:       ms = ELAPSED_W'($urandom_range(1023, 900));
         2:       ms = ELAPSED_W'($urandom_range(150));
         default: ms = ELAPSED_W'($urandom_range(700, 400));
      endcase
      if ($urandom_range(99) < 65)
         send_request(CMD_TICK, CHAN_W'($urandom_range(3)), 1'($urandom_range(1)), ms);
      else
         send_request(CMD_ENABLE, CHAN_W'($urandom_range(3)), 1'($urandom_range(1)), ms);
   endtask

   initial begin
      sb = new();
      sb.clear();
      calm   = 1'b0;
      phases = 0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_TICK;
      req_bus.channel    <= '0;
      req_bus.enable     <= 1'b0;
      req_bus.elapsed_ms <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short period, period zero, all-ones setting, on time zero
      load_settings({16'h0200, 16'hFFFF, 16'h0005, 16'h0301});
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd1023);  // counters move while disabled
      send_request(CMD_ENABLE, 2'd0, 1'b1, 10'd1023);
      send_request(CMD_ENABLE, 2'd1, 1'b1, 10'd0);
      send_request(CMD_ENABLE, 2'd2, 1'b1, 10'd512);
      send_request(CMD_ENABLE, 2'd3, 1'b1, 10'd1);     // on time zero keeps pin low
      send_request(CMD_ENABLE, 2'd0, 1'b1, 10'd0);     // already on
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd0);
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd977);   // lands exactly on a second
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd999);
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd1);
      send_request(CMD_TICK,   2'd3, 1'b1, 10'd1023);  // channel/enable ignored
      send_request(CMD_ENABLE, 2'd1, 1'b0, 10'd300);
      send_request(CMD_ENABLE, 2'd1, 1'b0, 10'd0);     // already off
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd1023);
      send_request(CMD_TICK,   2'd2, 1'b0, 10'd1023);
      send_request(CMD_ENABLE, 2'd1, 1'b1, 10'd0);
      send_request(CMD_ENABLE, 2'd3, 1'b0, 10'd0);
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd512);
      send_request(CMD_TICK,   2'd0, 1'b0, 10'd512);
      send_request(CMD_ENABLE, 2'd0, 1'b0, 10'd0);
      send_request(CMD_ENABLE, 2'd2, 1'b0, 10'd0);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         if (p == 3)
            load_settings({16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF});
         else
            load_settings({pick_setting(), pick_setting(), pick_setting(), pick_setting()});
         calm = (p == 1);
         for (int n = 0; n < 76; n++)
            random_request();
         calm = 1'b0;
         wait_idle();
      end

      repeat (4) @(posedge clock);
      $display("run covered %0d transactions over %0d setting phases (%0d register writes)",
               sb.checked, phases, sb.setting_writes);
      $display("  %0d ticks, %0d whole seconds, %0d enable commands, %0d errors",
               sb.ticks, sb.seconds, sb.enable_cmds, sb.failures());
      if (sb.failures() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/mcsp_pkg.sv
sv/mcsp_req_if.sv
sv/mcsp_rsp_if.sv
sv/multi_channel_slow_pwm.sv
tb/sv/tb_multi_channel_slow_pwm.sv
